// ----- sv/adpd_pkg.sv -----
// ----------------------------------------------------------------------------
// adpd_pkg
// Shared types and constants of the attribute display pixel decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package adpd_pkg;

  localparam int unsigned AttrCells    = 768;
  localparam int unsigned AttrAw       = $clog2(AttrCells);
  localparam int unsigned AttrW        = 8;
  localparam int unsigned DisplayBytes = 6144;
  localparam int unsigned OffW         = 13;
  localparam int unsigned TickW        = 32;
  localparam int unsigned IntervalW    = 16;
  localparam int unsigned PixIdxW      = 16;
  localparam int unsigned ColourW      = 4;

  localparam logic [IntervalW-1:0] FlashIntervalReset = IntervalW'(62);

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_ATTR  = 2'd1,
    OP_PIXEL = 2'd2
  } op_t;

  // One display byte handed from the front end to the pixel serializer.
  typedef struct packed {
    logic [7:0] row;    // pixel row 0..191
    logic [4:0] col;    // byte column 0..31
    logic [7:0] bits;   // bitmap byte, MSB is the left pixel
    logic       phase;  // flash phase seen by this byte
  } pix_job_t;

endpackage : adpd_pkg

`default_nettype wire

// ----- sv/adpd_in_if.sv -----
// ----------------------------------------------------------------------------
// adpd_in_if
// Input channel: frame start, attribute write and display byte words.
// ----------------------------------------------------------------------------
`default_nettype none

interface adpd_in_if import adpd_pkg::*; ();
  logic                valid;
  logic                ready;
  op_t                 op;
  logic [TickW-1:0]    tick;
  logic [AttrAw-1:0]   attr_index;
  logic [OffW-1:0]     display_offset;
  logic [7:0]          data_byte;

  modport source(output valid, op, tick, attr_index, display_offset, data_byte,
                 input ready);
  modport sink(input valid, op, tick, attr_index, display_offset, data_byte,
               output ready);
endinterface : adpd_in_if

`default_nettype wire

// ----- sv/adpd_out_if.sv -----
// ----------------------------------------------------------------------------
// adpd_out_if
// Result channel: one pixel word with its linear index and colour.
// ----------------------------------------------------------------------------
`default_nettype none

interface adpd_out_if import adpd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PixIdxW-1:0]  pixel_index;
  logic [ColourW-1:0]  colour_id;
  logic                last;

  modport source(output valid, pixel_index, colour_id, last, input ready);
  modport sink(input valid, pixel_index, colour_id, last, output ready);
endinterface : adpd_out_if

`default_nettype wire

// ----- sv/attribute_display_pixel_decoder.sv -----
// ----------------------------------------------------------------------------
// attribute_display_pixel_decoder
// Decodes interleaved bitmap bytes with cell attributes into pixel colours.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries three kinds of word, chosen by op: frame start (tick
//   advances the flash phase), attribute write (one byte into the 768-cell
//   attribute RAM) and display byte (offset and bitmap byte).
//   out_ch gives eight pixel words per display byte, left pixel first, with
//   last set on the eighth. Display bytes past the display file, attribute
//   writes past the last cell and op 3 are dropped.
//   cfg_we/cfg_wdata write flash_interval (reset 62); write only while idle.
// Timing:
//   A word is registered on accept; a display byte reads the attribute RAM
//   when the serializer can take it, and its pixels leave from the
//   serializer's output register. The serializer sends one pixel per cycle
//   while out_ch.ready is high; other words never wait for the serializer.
//   A new word is taken while pixels of the previous byte are still going.
// Reset:
//   Flash phase and last toggle tick clear. The attribute RAM is then zeroed,
//   one cell per cycle, with in_ch.ready low until all 768 cells are clear.
// Stall:
//   When out_ch.ready is low the pixel word holds, the serializer waits and
//   back-pressure reaches in_ch.ready once the input register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module attribute_display_pixel_decoder import adpd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [IntervalW-1:0] cfg_wdata,
  adpd_in_if.sink                   in_ch,
  adpd_out_if.source                out_ch
);

  logic [IntervalW-1:0] flash_interval_r;

  logic                 s1_valid_r, s1_valid_nxt;
  op_t                  s1_op_r;
  logic [TickW-1:0]     s1_tick_r;
  logic [AttrAw-1:0]    s1_aidx_r;
  logic [OffW-1:0]      s1_off_r;
  logic [7:0]           s1_data_r;

  logic                 flash_phase_r, flash_phase_nxt;
  logic [TickW-1:0]     last_tick_r, last_tick_nxt;

  logic                 clearing_r, clearing_nxt;
  logic [AttrAw-1:0]    clr_cnt_r, clr_cnt_nxt;

  logic                 is_frame, is_attr, is_pix;
  logic                 s1_adv;
  logic                 in_acc;
  logic                 job_free;
  logic [TickW-1:0]     tick_diff;
  logic                 toggle;

  logic                 ram_we;
  logic [AttrAw-1:0]    ram_waddr;
  logic [AttrW-1:0]     ram_wdata;
  logic                 ram_re;
  logic [AttrAw-1:0]    ram_raddr;
  logic [AttrW-1:0]     ram_rdata;
  pix_job_t             job;

  // Decode the held word.
  always_comb begin
    is_frame = 1'b0;
    is_attr  = 1'b0;
    is_pix   = 1'b0;
    unique case (s1_op_r)
      OP_FRAME: is_frame = 1'b1;
      OP_ATTR:  is_attr  = (32'(s1_aidx_r) < AttrCells);
      OP_PIXEL: is_pix   = (32'(s1_off_r) < DisplayBytes);
      default:  ;
    endcase
  end

  assign s1_adv      = s1_valid_r && (!is_pix || job_free);
  assign in_ch.ready = !clearing_r && (!s1_valid_r || s1_adv);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign tick_diff = s1_tick_r - last_tick_r;
  assign toggle    = s1_adv && is_frame && (tick_diff > TickW'(flash_interval_r));

  always_comb begin
    s1_valid_nxt    = in_acc || (s1_valid_r && !s1_adv);
    flash_phase_nxt = flash_phase_r;
    last_tick_nxt   = last_tick_r;
    if (toggle) begin
      flash_phase_nxt = !flash_phase_r;
      last_tick_nxt   = s1_tick_r;
    end
    clearing_nxt = clearing_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clearing_r) begin
      clr_cnt_nxt = clr_cnt_r + AttrAw'(1);
      if (clr_cnt_r == AttrAw'(AttrCells - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flash_interval_r <= FlashIntervalReset;
      s1_valid_r       <= 1'b0;
      flash_phase_r    <= 1'b0;
      last_tick_r      <= '0;
      clearing_r       <= 1'b1;
      clr_cnt_r        <= '0;
    end else begin
      if (cfg_we) begin
        flash_interval_r <= cfg_wdata;
      end
      s1_valid_r    <= s1_valid_nxt;
      flash_phase_r <= flash_phase_nxt;
      last_tick_r   <= last_tick_nxt;
      clearing_r    <= clearing_nxt;
      clr_cnt_r     <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= in_ch.op;
      s1_tick_r <= in_ch.tick;
      s1_aidx_r <= in_ch.attr_index;
      s1_off_r  <= in_ch.display_offset;
      s1_data_r <= in_ch.data_byte;
    end
  end

  // Zero the RAM after reset, then take attribute writes.
  assign ram_we    = clearing_r || (s1_adv && is_attr);
  assign ram_waddr = clearing_r ? clr_cnt_r : s1_aidx_r;
  assign ram_wdata = clearing_r ? '0 : s1_data_r;

  // Cell of a display byte: third, character row, byte column.
  assign ram_re    = s1_adv && is_pix;
  assign ram_raddr = {s1_off_r[12:11], s1_off_r[7:5], s1_off_r[4:0]};

  assign job.row   = {s1_off_r[12:11], s1_off_r[7:5], s1_off_r[10:8]};
  assign job.col   = s1_off_r[4:0];
  assign job.bits  = s1_data_r;
  assign job.phase = flash_phase_r;

  adpd_ram #(
    .WIDTH(AttrW),
    .DEPTH(AttrCells)
  ) u_attr_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  adpd_serializer u_ser (
    .clk     (clk),
    .rst_n   (rst_n),
    .job_load(ram_re),
    .job     (job),
    .attr    (ram_rdata),
    .job_free(job_free),
    .out_ch  (out_ch)
  );

endmodule : attribute_display_pixel_decoder

`default_nettype wire

// ----- sv/adpd_ram.sv -----
// ----------------------------------------------------------------------------
// adpd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module adpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule : adpd_ram

`default_nettype wire

// ----- sv/adpd_serializer.sv -----
// ----------------------------------------------------------------------------
// adpd_serializer
// Expands one display byte into eight pixel words, one per cycle while out_ch.ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module adpd_serializer import adpd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             job_load,
  input  wire pix_job_t         job,
  input  wire logic [AttrW-1:0] attr,
  output logic                  job_free,
  adpd_out_if.source            out_ch
);

  pix_job_t            job_r;
  logic                active_r, active_nxt;
  logic [2:0]          k_r, k_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [PixIdxW-1:0]  pix_idx_r;
  logic [ColourW-1:0]  colour_r;
  logic                last_r;
  logic                out_load;
  logic                pix_bit;
  logic                swap;
  logic [2:0]          ink;
  logic [2:0]          paper;
  logic [2:0]          base;

  assign out_load = active_r && (!out_valid_r || out_ch.ready);
  assign job_free = !active_r || (out_load && (k_r == 3'd7));

  // attr comes from the RAM read issued with job_load and holds meanwhile.
  always_comb begin
    pix_bit = job_r.bits[3'd7 - k_r];
    swap    = attr[7] && job_r.phase;
    ink     = swap ? attr[5:3] : attr[2:0];
    paper   = swap ? attr[2:0] : attr[5:3];
    base    = pix_bit ? ink : paper;
  end

  always_comb begin
    active_nxt    = active_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      k_nxt         = k_r + 3'd1;
      if (k_r == 3'd7) begin
        active_nxt = 1'b0;
      end
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (job_load) begin
      active_nxt = 1'b1;
      k_nxt      = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      k_r         <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job_r <= job;
    end
    if (out_load) begin
      pix_idx_r <= {job_r.row, job_r.col, k_r};
      colour_r  <= {attr[6], base};
      last_r    <= (k_r == 3'd7);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_index = pix_idx_r;
  assign out_ch.colour_id   = colour_r;
  assign out_ch.last        = last_r;

endmodule : adpd_serializer

`default_nettype wire

// ----- sv/adpd_checker.sv -----
// ----------------------------------------------------------------------------
// adpd_checker
// Port-level checks of the pixel decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module adpd_checker import adpd_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [PixIdxW-1:0] out_pixel_index,
  input wire logic [ColourW-1:0] out_colour_id,
  input wire logic               out_last
);

  // A stalled pixel word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_index) &&
      $stable(out_colour_id) && $stable(out_last))
    else $error("pixel word changed while stalled");

  // Pixels of one byte leave back to back at consecutive indexes.
  a_next_pix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && (out_pixel_index == $past(out_pixel_index) + PixIdxW'(1)))
    else $error("pixel sequence of a byte broken");

  // last marks the right pixel of a byte and pixels stay on screen.
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_pixel_index[2:0] == 3'b111)) &&
      (out_pixel_index < PixIdxW'(49152)))
    else $error("bad pixel position or last flag");

  // The attribute RAM clear keeps the input closed right after reset.
  a_clear_closed: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_ready)
    else $error("input open during attribute clear");

endmodule : adpd_checker

bind attribute_display_pixel_decoder adpd_checker u_adpd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_pixel_index(out_ch.pixel_index),
  .out_colour_id  (out_ch.colour_id),
  .out_last       (out_ch.last)
);

`default_nettype wire
